@@ rtl/core/aes128_block_cipher_custom_rcon_unit_assert.svh @@
// Assertion macros for the cipher unit.
`ifndef AES128_BLOCK_CIPHER_CUSTOM_RCON_UNIT_ASSERT_SVH
`define AES128_BLOCK_CIPHER_CUSTOM_RCON_UNIT_ASSERT_SVH

// same-cycle implication
`define AESC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AESC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/aesc_pkg.sv @@
package aesc_pkg;

  localparam int ROUNDS = 10;

  typedef enum logic [1:0] {
    ST_KLOAD,
    ST_EXPAND,
    ST_IDLE,
    ST_RUN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_key;   // key_work <= key registers
    logic       exp_step;   // one forward key schedule step
    logic       store_k10;  // keep last round key
    logic       load_blk;   // load block, add first round key
    logic       rnd_step;   // one cipher round
    logic       dec;
    logic       last;
    logic [3:0] rc_idx;
  } ctl_cmd_t;

  localparam logic [7:0] RCON [ROUNDS] = '{
    8'h02, 8'h03, 8'h05, 8'h06, 8'h70, 8'h80, 8'h90, 8'h10, 8'h5b, 8'h56
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

endpackage

@@ rtl/core/aesc_ctrl.sv @@
module aesc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                cmd,
  input  logic                key_wr,
  output logic                busy,
  output logic                done,
  output aesc_pkg::ctl_cmd_t  ctl
);

  aesc_pkg::state_t state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       dec, dec_next;
  logic       done_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aesc_pkg::ST_KLOAD;
      cnt   <= '0;
      dec   <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      dec   <= dec_next;
      done  <= done_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    dec_next   = dec;
    done_next  = 1'b0;
    ctl        = '0;
    ctl.dec    = dec;
    ctl.last   = (cnt == 4'(aesc_pkg::ROUNDS - 1));
    ctl.rc_idx = dec ? 4'(aesc_pkg::ROUNDS - 1) - cnt : cnt;
    case (state)
      aesc_pkg::ST_KLOAD: begin
        ctl.load_key = 1'b1;
        cnt_next     = '0;
        state_next   = aesc_pkg::ST_EXPAND;
      end
      aesc_pkg::ST_EXPAND: begin
        ctl.dec      = 1'b0;
        ctl.rc_idx   = cnt;
        ctl.exp_step = 1'b1;
        ctl.store_k10 = ctl.last;
        cnt_next     = cnt + 4'd1;
        if (ctl.last) state_next = aesc_pkg::ST_IDLE;
      end
      aesc_pkg::ST_IDLE: begin
        if (start) begin
          ctl.load_blk = 1'b1;
          ctl.dec      = cmd;
          dec_next     = cmd;
          cnt_next     = '0;
          state_next   = aesc_pkg::ST_RUN;
        end
      end
      aesc_pkg::ST_RUN: begin
        ctl.rnd_step = 1'b1;
        cnt_next     = cnt + 4'd1;
        if (ctl.last) begin
          done_next  = 1'b1;
          state_next = aesc_pkg::ST_IDLE;
        end
      end
      default: state_next = aesc_pkg::ST_KLOAD;
    endcase
    // a key write restarts the schedule
    if (key_wr) begin
      state_next = aesc_pkg::ST_KLOAD;
      done_next  = 1'b0;
    end
  end

  assign busy = (state != aesc_pkg::ST_IDLE);

endmodule

@@ rtl/core/aesc_dp.sv @@
module aesc_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic [63:0]         block_high,
  input  logic [63:0]         block_low,
  input  aesc_pkg::ctl_cmd_t  ctl,
  output logic [63:0]         out_high,
  output logic [63:0]         out_low
);

  logic [63:0]  key_high, key_low;
  logic [127:0] k10;
  logic [127:0] key_work, key_n;
  logic [127:0] st, rnd_out, blk_in;

  function automatic logic [7:0] xt(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {aesc_pkg::SBOX[w[31:24]], aesc_pkg::SBOX[w[23:16]],
            aesc_pkg::SBOX[w[15:8]], aesc_pkg::SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [3:0] idx);
    logic [31:0] t, n0, n1, n2, n3;
    t  = sub_word({k[23:0], k[31:24]}) ^ {aesc_pkg::RCON[idx], 24'h0};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [127:0] key_inv(input logic [127:0] k, input logic [3:0] idx);
    logic [31:0] t, p0, p1, p2, p3;
    p3 = k[31:0] ^ k[63:32];
    p2 = k[63:32] ^ k[95:64];
    p1 = k[95:64] ^ k[127:96];
    t  = sub_word({p3[23:0], p3[31:24]}) ^ {aesc_pkg::RCON[idx], 24'h0};
    p0 = k[127:96] ^ t;
    return {p0, p1, p2, p3};
  endfunction

  // word j goes into column j, top byte into row 0
  function automatic logic [127:0] add_key(input logic [127:0] s, input logic [127:0] k);
    logic [127:0] r;
    r = s;
    for (int c = 0; c < 4; c++) begin
      for (int rw = 0; rw < 4; rw++) begin
        r[127 - 8 * (rw * 4 + c) -: 8] = s[127 - 8 * (rw * 4 + c) -: 8]
                                        ^ k[127 - 32 * c - 8 * rw -: 8];
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] shift(input logic [127:0] s, input logic fwd);
    logic [127:0] r;
    r = s;
    for (int rw = 1; rw < 4; rw++) begin
      for (int c = 0; c < 4; c++) begin
        r[127 - 8 * (rw * 4 + c) -: 8] =
          s[127 - 8 * (rw * 4 + (fwd ? ((c + rw) & 3) : ((c - rw + 4) & 3))) -: 8];
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] subst(input logic [127:0] s, input logic fwd);
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      r[127 - 8 * i -: 8] = fwd ? aesc_pkg::SBOX[s[127 - 8 * i -: 8]]
                                : aesc_pkg::INV_SBOX[s[127 - 8 * i -: 8]];
    end
    return r;
  endfunction

  function automatic logic [127:0] mix_fwd(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 8 * c -: 8];
      a1 = s[127 - 8 * (c + 4) -: 8];
      a2 = s[127 - 8 * (c + 8) -: 8];
      a3 = s[127 - 8 * (c + 12) -: 8];
      r[127 - 8 * c -: 8]        = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      r[127 - 8 * (c + 4) -: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      r[127 - 8 * (c + 8) -: 8]  = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      r[127 - 8 * (c + 12) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return r;
  endfunction

  // x*9, x*11, x*13, x*14 from doubling chain
  function automatic logic [127:0] mix_inv(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        a[i]  = s[127 - 8 * (c + 4 * i) -: 8];
        m2[i] = xt(a[i]);
        m4[i] = xt(m2[i]);
        m8[i] = xt(m4[i]);
        m9[i] = m8[i] ^ a[i];
        mb[i] = m8[i] ^ m2[i] ^ a[i];
        md[i] = m8[i] ^ m4[i] ^ a[i];
        me[i] = m8[i] ^ m4[i] ^ m2[i];
      end
      r[127 - 8 * c -: 8]        = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      r[127 - 8 * (c + 4) -: 8]  = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      r[127 - 8 * (c + 8) -: 8]  = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      r[127 - 8 * (c + 12) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    end
    return r;
  endfunction

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      if (cfg_index) key_low <= cfg_data;
      else key_high <= cfg_data;
    end
  end

  // one key schedule step, forward or backward
  assign key_n = ctl.dec ? key_inv(key_work, ctl.rc_idx) : key_fwd(key_work, ctl.rc_idx);

  // one cipher round
  always_comb begin
    if (!ctl.dec) begin
      rnd_out = shift(subst(st, 1'b1), 1'b1);
      if (!ctl.last) rnd_out = mix_fwd(rnd_out);
      rnd_out = add_key(rnd_out, key_n);
    end else begin
      rnd_out = add_key(subst(shift(st, 1'b0), 1'b0), key_n);
      if (!ctl.last) rnd_out = mix_inv(rnd_out);
    end
  end

  assign blk_in = add_key({block_high, block_low}, ctl.dec ? k10 : {key_high, key_low});

  // round key and state registers
  always_ff @(posedge clk) begin
    if (ctl.load_key) key_work <= {key_high, key_low};
    else if (ctl.load_blk) key_work <= ctl.dec ? k10 : {key_high, key_low};
    else if (ctl.exp_step || ctl.rnd_step) key_work <= key_n;
    if (ctl.store_k10) k10 <= key_n;
    if (ctl.load_blk) st <= blk_in;
    else if (ctl.rnd_step) st <= rnd_out;
  end

  assign out_high = st[127:64];
  assign out_low  = st[63:0];

endmodule

@@ rtl/core/aes128_block_cipher_custom_rcon_unit.sv @@
// After start is accepted the rounds run in ST_RUN; done rises once the last
// round result is in the state register that drives out_high/out_low.
// A new word is taken only after the last one is through; start is taken again in the done cycle.
// After reset or any key write the key schedule runs (ST_KLOAD, then ST_EXPAND) with busy high.
// done marks out_high/out_low for one cycle; the receiver cannot stall.
// Reset: synchronous, active high; key registers clear to zero.
module aes128_block_cipher_custom_rcon_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        cmd,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);

`include "aes128_block_cipher_custom_rcon_unit_assert.svh"

  aesc_pkg::ctl_cmd_t ctl;

  aesc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .key_wr (cfg_we),
    .busy   (busy),
    .done   (done),
    .ctl    (ctl)
  );

  aesc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .block_high (block_high),
    .block_low  (block_low),
    .ctl        (ctl),
    .out_high   (out_high),
    .out_low    (out_low)
  );

  // checks
  `AESC_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `AESC_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `AESC_ASSERT_NOW(a_one_cmd, clk, rst, 1'b1, $onehot0({ctl.load_key, ctl.exp_step, ctl.load_blk, ctl.rnd_step}))

endmodule

@@ dv/aes128_block_cipher_custom_rcon_unit_tb.sv @@
`timescale 1ns / 100ps

module aes128_block_cipher_custom_rcon_unit_tb;

  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW = 1'b1;
  localparam int NUM_RANDOM = 1300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic        op;
    logic [63:0] hi;
    logic [63:0] lo;
  } block_row_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        done;
  logic        cmd = CMD_ENC;
  logic [63:0] block_high = '0;
  logic [63:0] block_low = '0;
  logic [63:0] out_high;
  logic [63:0] out_low;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;

  // predictor state
  logic [63:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;
  logic [31:0] sched [44];
  block_word_t cipher_q [$];

  int  n_fail = 0;
  int  n_words = 0;
  int  n_results = 0;
  int  n_keys = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;

  aes128_block_cipher_custom_rcon_unit dut (.*);

  always #5 clk = ~clk;

  // key schedule with this unit's own round constants
  function automatic void expand_keys();
    logic [31:0] t;
    sched[0] = key_hi_q[63:32];
    sched[1] = key_hi_q[31:0];
    sched[2] = key_lo_q[63:32];
    sched[3] = key_lo_q[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {aesc_pkg::SBOX[t[31:24]], aesc_pkg::SBOX[t[23:16]],
             aesc_pkg::SBOX[t[15:8]], aesc_pkg::SBOX[t[7:0]]};
        t[31:24] ^= aesc_pkg::RCON[i/4 - 1];
      end
      sched[i] = sched[i-4] ^ t;
    end
  endfunction

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p ^= a;
      a = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    end
    return p;
  endfunction

  function automatic block_word_t cipher_block(logic op, logic [63:0] hi, logic [63:0] lo);
    logic [7:0] m [16];
    logic [7:0] t [16];
    logic [7:0] a [4];
    logic [7:0] cf [4];
    logic [31:0] w;
    block_word_t res;
    int rk;
    for (int i = 0; i < 8; i++) begin
      m[i] = hi[63-8*i -: 8];
      m[i+8] = lo[63-8*i -: 8];
    end
    if (op == CMD_ENC) cf = '{8'h02, 8'h03, 8'h01, 8'h01};
    else cf = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    // 0: initial key add, 1..10: rounds
    for (int s = 0; s <= aesc_pkg::ROUNDS; s++) begin
      rk = (op == CMD_ENC) ? s : aesc_pkg::ROUNDS - s;
      if (s > 0) begin
        // byte substitution and row rotation commute, so one order serves both ways
        t = m;
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++)
            m[r*4+c] = (op == CMD_ENC) ? aesc_pkg::SBOX[t[r*4 + ((c + r) & 3)]]
                                       : aesc_pkg::INV_SBOX[t[r*4 + ((c - r + 4) & 3)]];
        // encrypt mixes before the key add
        if (op == CMD_ENC && s < aesc_pkg::ROUNDS)
          for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = m[c+4*r];
            for (int r = 0; r < 4; r++)
              m[c+4*r] = gf_mul(cf[(4-r)&3], a[0]) ^ gf_mul(cf[(5-r)&3], a[1])
                       ^ gf_mul(cf[(6-r)&3], a[2]) ^ gf_mul(cf[(7-r)&3], a[3]);
          end
      end
      for (int c = 0; c < 4; c++) begin
        w = sched[4*rk + c];
        m[c] ^= w[31:24];
        m[c+4] ^= w[23:16];
        m[c+8] ^= w[15:8];
        m[c+12] ^= w[7:0];
      end
      // decrypt mixes after the key add
      if (op == CMD_DEC && s > 0 && s < aesc_pkg::ROUNDS)
        for (int c = 0; c < 4; c++) begin
          for (int r = 0; r < 4; r++) a[r] = m[c+4*r];
          for (int r = 0; r < 4; r++)
            m[c+4*r] = gf_mul(cf[(4-r)&3], a[0]) ^ gf_mul(cf[(5-r)&3], a[1])
                     ^ gf_mul(cf[(6-r)&3], a[2]) ^ gf_mul(cf[(7-r)&3], a[3]);
        end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = m[i];
      res.lo[63-8*i -: 8] = m[i+8];
    end
    return res;
  endfunction

  // present one word; returns after an edge at which busy reads low
  task automatic send_word(logic op, logic [63:0] hi, logic [63:0] lo);
    if (!no_idle && $urandom_range(99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= op;
    block_high <= hi;
    block_low <= lo;
    @(posedge clk);
    while (busy) @(posedge clk);
    cipher_q.push_back(cipher_block(op, hi, lo));
    n_words++;
  endtask

  // key writes only with the unit idle
  task automatic write_key(logic idx, logic [63:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KEY_HIGH) key_hi_q = val;
    else key_lo_q = val;
    expand_keys();
    n_keys++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // result checker
  always @(posedge clk) begin
    block_word_t exp_w;
    if (!rst && done) begin
      n_results++;
      if (cipher_q.size() == 0) begin
        $error("result with nothing pending: out_high=%h out_low=%h", out_high, out_low);
        n_fail++;
      end else begin
        exp_w = cipher_q.pop_front();
        if (out_high !== exp_w.hi) begin
          $error("out_high expected %h actual %h", exp_w.hi, out_high);
          n_fail++;
        end
        if (out_low !== exp_w.lo) begin
          $error("out_low expected %h actual %h", exp_w.lo, out_low);
          n_fail++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("aes128_block_cipher_custom_rcon_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    block_row_t dir_rows [$];
    block_word_t pt;
    int wait_cnt;
    logic [63:0] kh, kl;

    expand_keys();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed words: field extremes, both operations, single set bits
    dir_rows = '{
      '{CMD_ENC, 64'h0, 64'h0},
      '{CMD_DEC, 64'h0, 64'h0},
      '{CMD_ENC, '1, '1},
      '{CMD_DEC, '1, '1},
      '{CMD_ENC, 64'h8000_0000_0000_0000, 64'h0},
      '{CMD_ENC, 64'h0, 64'h0000_0000_0000_0001},
      '{CMD_DEC, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000},
      '{CMD_ENC, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff},
      '{CMD_DEC, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff},
      '{CMD_ENC, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555},
      '{CMD_DEC, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa}
    };
    foreach (dir_rows[i]) send_word(dir_rows[i].op, dir_rows[i].hi, dir_rows[i].lo);

    // extreme keys, then words under each
    write_key(REG_KEY_HIGH, '1);
    write_key(REG_KEY_LOW, '1);
    foreach (dir_rows[i]) send_word(dir_rows[i].op, dir_rows[i].hi, dir_rows[i].lo);
    write_key(REG_KEY_HIGH, 64'h0);
    send_word(CMD_ENC, 64'h0, '1);
    write_key(REG_KEY_LOW, 64'h0);
    send_word(CMD_DEC, '1, 64'h0);

    // random words in phases, one key half rewritten between phases
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 200 == 100) begin
        kh = ($urandom_range(9) == 0) ? '1 : rand64();
        kl = ($urandom_range(9) == 0) ? 64'h0 : rand64();
        if ($urandom_range(1)) write_key(REG_KEY_HIGH, kh);
        else write_key(REG_KEY_LOW, kl);
      end
      no_idle = (i >= 400 && i < 650);
      if ($urandom_range(3) == 0 && i > 0) begin
        // round trip: decrypt the model's encryption of a fresh random block
        pt = cipher_block(CMD_ENC, rand64(), rand64());
        send_word(CMD_DEC, pt.hi, pt.lo);
      end else begin
        send_word($urandom_range(1), rand64(), rand64());
      end
    end
    start <= 1'b0;

    // drain
    wait_cnt = 0;
    while (cipher_q.size() != 0 && wait_cnt < 1000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cipher_q.size() != 0) begin
      $error("%0d results never arrived", cipher_q.size());
      n_fail++;
    end

    $display("sent %0d words (encrypt and decrypt), checked %0d results, %0d key writes",
             n_words, n_results, n_keys);
    if (n_fail == 0) begin
      $display("aes128_block_cipher_custom_rcon_unit_tb OK");
    end else begin
      $display("aes128_block_cipher_custom_rcon_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
